FILE: sv/tsp_pkg.sv
// ----------------------------------------------------------------------------
// tsp_pkg
// Types and constants shared by the trapezoid speed profile planner.
// ----------------------------------------------------------------------------
package tsp_pkg;

    localparam int POS_W   = 32;
    localparam int FRAC_W  = 16;
    localparam int SPEED_W = 31;
    localparam int SQ_W    = 2 * SPEED_W;
    localparam int PROD_W  = SQ_W + POS_W;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_START_POS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_POS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACC_FRAC  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEC_FRAC  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_SPEED = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SQ    = 3'd5;

    localparam logic [FRAC_W-1:0]  ACC_FRAC_RST  = 16'd16384;
    localparam logic [FRAC_W-1:0]  DEC_FRAC_RST  = 16'd16384;
    localparam logic [SPEED_W-1:0] TOP_SPEED_RST = 31'd65536;
    localparam logic [SPEED_W-1:0] MIN_SQ_RST    = 31'd655;

    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        PH_ACCEL  = 2'd0,
        PH_CRUISE = 2'd1,
        PH_DECEL  = 2'd2,
        PH_END    = 2'd3
    } phase_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_MUL_A,
        S_MUL_E,
        S_MUL_T,
        S_DECIDE,
        S_MUL_L,
        S_MUL_H,
        S_DIV,
        S_COMB,
        S_SQRT,
        S_FIN,
        S_OUT
    } state_t;

endpackage

FILE: sv/trapezoid_speed_profile.sv
// ----------------------------------------------------------------------------
// trapezoid_speed_profile
// Distance-based trapezoidal speed planner, Q16.16, one shared multiplier,
// a bit-serial divider and a bit-pair square root under one sequencer.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          contents
//  s_*       in   s_tvalid/s_tready  tdata position, tuser command
//  m_*       out  m_tvalid/m_tready  tdata planned speed, tuser phase/done/error
//  cfg_*     in   cfg_valid/cfg_ready register index and data, always ready
//
//  start command or bad-settings sample: no arithmetic; cruise, end, zero speed:
//  no division or root; zero accelerate or decelerate distance: no division;
//  other accelerate and decelerate samples: 94-step divider, 32-step square root
//  one word at a time: s_tready is high only while the sequencer is idle
//  a result not yet taken holds the next word in its last cycle until m_tready
//  aresetn is synchronous; configuration registers reset to their defaults
// ----------------------------------------------------------------------------
module trapezoid_speed_profile (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tsp_pkg::POS_W-1:0]       s_tdata,   // current_position
    input  logic [0:0]                      s_tuser,   // command
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tsp_pkg::POS_W-1:0]       m_tdata,   // planned_speed
    output logic [3:0]                      m_tuser,   // phase[1:0], done_res, setting_error
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tsp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_data
);
    import tsp_pkg::*;

    state_t state_reg, state_next;

    logic [POS_W-1:0]   origin_reg, end_pos_reg;
    logic [FRAC_W-1:0]  acc_frac_reg, dec_frac_reg;
    logic [SPEED_W-1:0] top_reg, min_sq_reg;

    logic               cmd_reg, cmd_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [POS_W-1:0]   total_reg, total_next;
    logic [POS_W-1:0]   dist_reg, dist_next;
    logic               neg_reg, neg_next;
    logic [POS_W-1:0]   ad_reg, ad_next;
    logic [POS_W-1:0]   dd_reg, dd_next;
    logic [SQ_W-1:0]    tsq_reg, tsq_next;
    logic [POS_W-1:0]   num_reg, num_next;
    logic [POS_W-1:0]   div_reg, div_next;
    logic               sub_reg, sub_next;
    logic               accp_reg, accp_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [POS_W-1:0]   rem_reg, rem_next;
    logic [63:0]        quo_reg, quo_next;
    logic               ovf_reg, ovf_next;
    logic [6:0]         cnt_reg, cnt_next;
    logic [63:0]        sq_reg, sq_next;
    logic [63:0]        root_reg, root_next;
    logic [63:0]        bit_reg, bit_next;
    logic [SPEED_W-1:0] mag_reg, mag_next;
    logic               upd_reg, upd_next;
    logic [SPEED_W-1:0] speed_reg, speed_next;
    phase_t             phase_reg, phase_next;
    logic               done_reg, done_next;
    logic [1:0]         shown_reg, shown_next;
    logic               err_reg, err_next;

    logic               m_valid_reg, m_valid_next;
    logic [POS_W-1:0]   m_data_reg, m_data_next;
    logic [3:0]         m_user_reg, m_user_next;

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic [FRAC_W:0] frac_sum;
    logic            bad;
    assign frac_sum = {1'b0, acc_frac_reg} + {1'b0, dec_frac_reg};
    assign bad = frac_sum[FRAC_W] || (acc_frac_reg == '0) || (dec_frac_reg == '0)
                 || (top_reg == '0);

    logic [POS_W:0]   tot_diff, pos_diff;
    logic [POS_W:0]   tot_abs, pos_abs;
    logic [POS_W-1:0] acd;
    logic [POS_W:0]   r2;
    logic [64:0]      add_s;
    logic [63:0]      q_eff, root_bit;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_reg    <= '0;
            end_pos_reg   <= '0;
            acc_frac_reg  <= ACC_FRAC_RST;
            dec_frac_reg  <= DEC_FRAC_RST;
            top_reg       <= TOP_SPEED_RST;
            min_sq_reg    <= MIN_SQ_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_START_POS: origin_reg    <= cfg_data;
                REG_END_POS:   end_pos_reg   <= cfg_data;
                REG_ACC_FRAC:  acc_frac_reg  <= cfg_data[FRAC_W-1:0];
                REG_DEC_FRAC:  dec_frac_reg  <= cfg_data[FRAC_W-1:0];
                REG_TOP_SPEED: top_reg       <= cfg_data[SPEED_W-1:0];
                REG_MIN_SQ:    min_sq_reg    <= cfg_data[SPEED_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            phase_reg   <= PH_ACCEL;
            speed_reg   <= '0;
            done_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            speed_reg   <= speed_next;
            done_reg    <= done_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        pos_reg    <= pos_next;
        total_reg  <= total_next;
        dist_reg   <= dist_next;
        neg_reg    <= neg_next;
        ad_reg     <= ad_next;
        dd_reg     <= dd_next;
        tsq_reg    <= tsq_next;
        num_reg    <= num_next;
        div_reg    <= div_next;
        sub_reg    <= sub_next;
        accp_reg   <= accp_next;
        prod_reg   <= prod_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        ovf_reg    <= ovf_next;
        cnt_reg    <= cnt_next;
        sq_reg     <= sq_next;
        root_reg   <= root_next;
        bit_reg    <= bit_next;
        mag_reg    <= mag_next;
        upd_reg    <= upd_next;
        shown_reg  <= shown_next;
        err_reg    <= err_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        pos_next     = pos_reg;
        total_next   = total_reg;
        dist_next    = dist_reg;
        neg_next     = neg_reg;
        ad_next      = ad_reg;
        dd_next      = dd_reg;
        tsq_next     = tsq_reg;
        num_next     = num_reg;
        div_next     = div_reg;
        sub_next     = sub_reg;
        accp_next    = accp_reg;
        prod_next    = prod_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        ovf_next     = ovf_reg;
        cnt_next     = cnt_reg;
        sq_next      = sq_reg;
        root_next    = root_reg;
        bit_next     = bit_reg;
        mag_next     = mag_reg;
        upd_next     = upd_reg;
        speed_next   = speed_reg;
        phase_next   = phase_reg;
        done_next    = done_reg;
        shown_next   = shown_reg;
        err_next     = err_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;

        mul_a = '0;
        mul_b = '0;

        tot_diff = {end_pos_reg[POS_W-1], end_pos_reg}
                   - {origin_reg[POS_W-1], origin_reg};
        pos_diff = {pos_reg[POS_W-1], pos_reg} - {origin_reg[POS_W-1], origin_reg};
        tot_abs  = tot_diff[POS_W] ? ((POS_W+1)'(0) - tot_diff) : tot_diff;
        pos_abs  = pos_diff[POS_W] ? ((POS_W+1)'(0) - pos_diff) : pos_diff;
        acd      = total_reg - dd_reg;
        r2       = {rem_reg, prod_reg[PROD_W-1]};
        q_eff    = ovf_reg ? '1 : quo_reg;
        add_s    = '0;
        root_bit = root_reg + bit_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next   = s_tuser[0];
                    pos_next   = s_tdata;
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                total_next = tot_abs[POS_W-1:0];
                dist_next  = pos_abs[POS_W-1:0];
                neg_next   = tot_diff[POS_W] == 1'b0 && tot_diff != '0 ? 1'b0 : tot_diff[POS_W];
                err_next   = bad;
                mag_next   = '0;
                if (cmd_reg == CMD_START) begin
                    phase_next = PH_ACCEL;
                    done_next  = 1'b0;
                    shown_next = PH_ACCEL;
                    upd_next   = 1'b1;
                    state_next = S_OUT;
                end else if (bad) begin
                    shown_next = phase_reg;
                    upd_next   = 1'b0;
                    state_next = S_OUT;
                end else begin
                    upd_next   = 1'b1;
                    state_next = S_MUL_A;
                end
            end
            S_MUL_A: begin
                mul_a      = total_reg;
                mul_b      = {16'd0, acc_frac_reg};
                ad_next    = mul_p[POS_W+FRAC_W-1:FRAC_W];
                state_next = S_MUL_E;
            end
            S_MUL_E: begin
                mul_a      = total_reg;
                mul_b      = {16'd0, dec_frac_reg};
                dd_next    = mul_p[POS_W+FRAC_W-1:FRAC_W];
                state_next = S_MUL_T;
            end
            S_MUL_T: begin
                mul_a      = {1'b0, top_reg};
                mul_b      = {1'b0, top_reg};
                tsq_next   = mul_p[SQ_W-1:0];
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                rem_next = '0;
                quo_next = '0;
                ovf_next = 1'b0;
                cnt_next = '0;
                begin
                    phase_t ph;
                    ph = (dist_reg <= ad_reg) ? PH_ACCEL : phase_reg;
                    shown_next = ph;
                    phase_next = ph;
                    case (ph)
                        PH_ACCEL: begin
                            if (dist_reg >= ad_reg) begin
                                phase_next = PH_CRUISE;
                            end
                            accp_next = 1'b1;
                            sub_next  = 1'b0;
                            num_next  = dist_reg;
                            div_next  = ad_reg;
                            if (ad_reg == '0) begin
                                // ratio term taken as the full squared top speed
                                quo_next   = {2'b00, tsq_reg};
                                state_next = S_COMB;
                            end else begin
                                state_next = S_MUL_L;
                            end
                        end
                        PH_CRUISE: begin
                            mag_next = top_reg;
                            if (dist_reg >= acd) begin
                                phase_next = PH_DECEL;
                            end
                            state_next = S_OUT;
                        end
                        PH_DECEL: begin
                            accp_next = 1'b0;
                            div_next  = dd_reg;
                            if (dist_reg >= total_reg) begin
                                mag_next   = '0;
                                phase_next = PH_END;
                                shown_next = PH_END;
                                state_next = S_OUT;
                            end else if (dd_reg == '0) begin
                                sub_next   = 1'b1;
                                state_next = S_COMB;
                            end else begin
                                sub_next   = (dist_reg >= acd);
                                num_next   = (dist_reg >= acd) ? (dist_reg - acd)
                                                               : (acd - dist_reg);
                                state_next = S_MUL_L;
                            end
                        end
                        default: begin
                            mag_next   = speed_reg;
                            done_next  = 1'b1;
                            phase_next = PH_ACCEL;
                            shown_next = PH_END;
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_MUL_L: begin
                mul_a      = tsq_reg[31:0];
                mul_b      = num_reg;
                prod_next  = {{(PROD_W-64){1'b0}}, mul_p};
                state_next = S_MUL_H;
            end
            S_MUL_H: begin
                mul_a      = {{(64-SQ_W){1'b0}}, tsq_reg[SQ_W-1:32]};
                mul_b      = num_reg;
                prod_next  = prod_reg + {mul_p[PROD_W-33:0], 32'd0};
                state_next = S_DIV;
            end
            S_DIV: begin
                // restoring long division, one quotient bit per cycle
                if (r2 >= {1'b0, div_reg}) begin
                    rem_next = r2[POS_W-1:0] - div_reg;
                    quo_next = {quo_reg[62:0], 1'b1};
                end else begin
                    rem_next = r2[POS_W-1:0];
                    quo_next = {quo_reg[62:0], 1'b0};
                end
                ovf_next  = ovf_reg | quo_reg[63];
                prod_next = {prod_reg[PROD_W-2:0], 1'b0};
                cnt_next  = cnt_reg + 7'd1;
                if (cnt_reg == 7'(PROD_W - 1)) begin
                    state_next = S_COMB;
                end
            end
            S_COMB: begin
                if (accp_reg) begin
                    add_s = {1'b0, 17'd0, min_sq_reg, 16'd0} + {1'b0, q_eff};
                end else if (sub_reg) begin
                    add_s = {3'b000, tsq_reg} - {1'b0, q_eff};
                end else begin
                    add_s = {3'b000, tsq_reg} + {1'b0, q_eff};
                end
                sq_next    = add_s[64] ? '1 : add_s[63:0];
                root_next  = '0;
                bit_next   = 64'd1 << 62;
                state_next = S_SQRT;
            end
            S_SQRT: begin
                if (sq_reg >= root_bit) begin
                    sq_next   = sq_reg - root_bit;
                    root_next = (root_reg >> 1) + bit_reg;
                end else begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0]) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                mag_next   = (root_reg[63:SPEED_W] != '0) ? '1 : root_reg[SPEED_W-1:0];
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = neg_reg ? (POS_W'(0) - {1'b0, mag_reg}) : {1'b0, mag_reg};
                    m_user_next  = {err_reg, done_reg, shown_reg};
                    if (upd_reg) begin
                        speed_next = mag_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_err_zero_speed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[3] |-> m_tdata == '0)
        else $error("error result carries non-zero speed");

    a_sqrt_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SQRT |-> $onehot(bit_reg))
        else $error("root bit lost");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_OUT && (!m_valid_reg || m_tready) |=> m_tvalid && state_reg == S_IDLE)
        else $error("result word not loaded");

    a_start_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_PREP && cmd_reg == CMD_START |=> phase_reg == PH_ACCEL && !done_reg)
        else $error("start command did not re-arm");

endmodule
